// ===== rtl/core/raft_rx_pkg.sv =====
package raft_rx_pkg;

    // Store and field sizes
    localparam int LOG_DEPTH = 1024;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int TERM_W    = 32;

    localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

    typedef enum logic [1:0] {
        OP_VOTE   = 2'd0,
        OP_APPEND = 2'd1,
        OP_ENTRY  = 2'd2,
        OP_TIMER  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } role_t;

    // Input word, first field in the lowest bits
    typedef struct packed {
        logic [TERM_W-1:0] entry_term;
        logic [IDX_W-1:0]  leader_commit;
        logic [CNT_W-1:0]  entry_count;
        logic [TERM_W-1:0] ref_term;
        logic [IDX_W-1:0]  ref_index;
        logic [NODE_W-1:0] peer_id;
        logic [TERM_W-1:0] msg_term;
    } item_t;

    // Result word, first field in the lowest bits
    typedef struct packed {
        logic              log_full;
        logic [IDX_W-1:0]  last_index;
        logic [IDX_W-1:0]  commit_index;
        logic [1:0]        role;
        logic              accepted;
        logic [TERM_W-1:0] reply_term;
    } result_t;

    localparam int IN_W     = $bits(item_t);
    localparam int S_DATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W    = $bits(result_t);
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/raft_rpc_receiver_unit.sv =====
// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ------------------------------------------------
// s_*       in   s_tvalid/s_tready  s_tdata: message fields, s_tuser: opcode
// m_*       out  m_tvalid/m_tready  m_tdata: term, accepted, role, commit, last, full
// cfg_*     in   cfg_we             cfg_data: node identifier
//
// One word is accepted per cycle while the result register is not stalled. A word
// waits in the input stage while the log store read for its previous index completes,
// then updates state and, if it owes a reply, loads the result register as it leaves.
// Reset clears node and control state and the log bookkeeping; log store contents stay
// undefined, index 0 reads as term zero by logic. A stalled result register holds the input
// stage, which in turn drops s_tready; the pair refills in the cycle m_tready returns.
module raft_rpc_receiver_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // msg_term, peer_id, ref_index, ref_term, entry_count, leader_commit, entry_term
    input  logic [raft_rx_pkg::S_DATA_W-1:0]     s_tdata,
    // opcode
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // reply_term, accepted, role, commit_index, last_index, log_full
    output logic [raft_rx_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [raft_rx_pkg::NODE_W-1:0]       cfg_data
);

    localparam int IDX_W  = raft_rx_pkg::IDX_W;
    localparam int CNT_W  = raft_rx_pkg::CNT_W;
    localparam int NODE_W = raft_rx_pkg::NODE_W;
    localparam int TERM_W = raft_rx_pkg::TERM_W;

    // Node state
    logic [NODE_W-1:0]       node_id_reg;
    logic [TERM_W-1:0]       term_reg,        term_next;
    logic [NODE_W-1:0]       vote_target_reg, vote_target_next;
    logic                    vote_cast_reg,   vote_cast_next;
    raft_rx_pkg::role_t      role_reg,        role_next;
    logic [IDX_W-1:0]        last_idx_reg,    last_idx_next;
    logic [TERM_W-1:0]       last_term_reg,   last_term_next;
    logic [IDX_W-1:0]        commit_reg,      commit_next;
    logic                    hb_reg,          hb_next;
    logic [CNT_W-1:0]        cursor_reg,      cursor_next;
    logic [CNT_W-1:0]        left_reg,        left_next;

    // Input stage
    logic                    s1_valid_reg;
    raft_rx_pkg::item_t      s1_item_reg;
    raft_rx_pkg::opcode_t    s1_op_reg;
    raft_rx_pkg::item_t      in_item;
    logic                    in_fire;
    logic                    s1_fire;

    // Log store and read bypass
    logic [TERM_W-1:0]       log_mem [raft_rx_pkg::LOG_DEPTH];
    logic [TERM_W-1:0]       mem_rd_reg;
    logic                    fwd_hit_reg;
    logic [TERM_W-1:0]       fwd_data_reg;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [TERM_W-1:0]       prev_term;

    // Result
    logic                    out_valid_reg;
    raft_rx_pkg::result_t    out_data_reg;
    logic                    res_valid;
    logic                    res_acc;
    logic                    res_full;

    // Append header helpers; the end index keeps one spare bit so a large count
    // cannot wrap below the store size
    logic [CNT_W:0]          end_idx;
    logic                    grant;

    assign in_item  = raft_rx_pkg::item_t'(s_tdata[raft_rx_pkg::IN_W-1:0]);
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = raft_rx_pkg::M_DATA_W'(out_data_reg);

    // Previous-entry term: index 0 is the fixed zero entry, and a write landing at
    // the same edge as the read is forwarded.
    always_comb
    begin
        if (s1_item_reg.ref_index == '0)
            prev_term = '0;
        else if (fwd_hit_reg)
            prev_term = fwd_data_reg;
        else
            prev_term = mem_rd_reg;
    end

    assign end_idx = (CNT_W+1)'(s1_item_reg.ref_index) + (CNT_W+1)'(s1_item_reg.entry_count);

    always_comb
    begin
        term_next        = term_reg;
        vote_target_next = vote_target_reg;
        vote_cast_next   = vote_cast_reg;
        role_next        = role_reg;
        last_idx_next    = last_idx_reg;
        last_term_next   = last_term_reg;
        commit_next      = commit_reg;
        hb_next          = hb_reg;
        cursor_next      = cursor_reg;
        left_next        = left_reg;
        res_valid        = 1'b0;
        res_acc          = 1'b0;
        res_full         = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = cursor_reg[IDX_W-1:0];
        grant            = 1'b0;

        if (s1_fire)
        begin
            unique case (s1_op_reg)
                raft_rx_pkg::OP_VOTE:
                begin
                    res_valid = 1'b1;
                    if (s1_item_reg.msg_term >= term_reg)
                    begin
                        // Adopt a newer term: step down and forget the vote
                        if (s1_item_reg.msg_term > term_reg)
                        begin
                            term_next      = s1_item_reg.msg_term;
                            role_next      = raft_rx_pkg::ROLE_FOLLOWER;
                            vote_cast_next = 1'b0;
                        end
                        if (!vote_cast_next || vote_target_reg == s1_item_reg.peer_id)
                        begin
                            // Candidate log at least as up to date: last term, then index
                            if (last_term_reg != s1_item_reg.ref_term)
                                grant = last_term_reg < s1_item_reg.ref_term;
                            else
                                grant = last_idx_reg <= s1_item_reg.ref_index;
                            if (grant)
                            begin
                                vote_cast_next   = 1'b1;
                                vote_target_next = s1_item_reg.peer_id;
                                hb_next          = 1'b1;
                            end
                        end
                    end
                    res_acc = grant;
                end

                raft_rx_pkg::OP_APPEND:
                begin
                    // A new header drops any entries still pending
                    left_next = '0;
                    res_valid = 1'b1;
                    if (s1_item_reg.msg_term >= term_reg)
                    begin
                        hb_next = 1'b1;
                        if (s1_item_reg.msg_term > term_reg)
                        begin
                            term_next      = s1_item_reg.msg_term;
                            role_next      = raft_rx_pkg::ROLE_FOLLOWER;
                            vote_cast_next = 1'b0;
                        end
                        else if (role_reg == raft_rx_pkg::ROLE_CANDIDATE)
                            role_next = raft_rx_pkg::ROLE_FOLLOWER;

                        if (s1_item_reg.ref_index <= last_idx_reg &&
                            prev_term == s1_item_reg.ref_term)
                        begin
                            if (end_idx > (CNT_W+1)'(raft_rx_pkg::LOG_DEPTH - 1))
                                res_full = 1'b1;
                            else
                            begin
                                // Truncate to the matching entry and arm the entry writes
                                last_idx_next  = s1_item_reg.ref_index;
                                last_term_next = s1_item_reg.ref_term;
                                cursor_next    = {1'b0, s1_item_reg.ref_index} + 1'b1;
                                left_next      = s1_item_reg.entry_count;
                                if (s1_item_reg.leader_commit > commit_reg)
                                begin
                                    if ((CNT_W+1)'(s1_item_reg.leader_commit) < end_idx)
                                        commit_next = s1_item_reg.leader_commit;
                                    else
                                        commit_next = end_idx[IDX_W-1:0];
                                end
                                if (s1_item_reg.entry_count == '0)
                                    res_acc = 1'b1;
                                else
                                    res_valid = 1'b0;
                            end
                        end
                    end
                end

                raft_rx_pkg::OP_ENTRY:
                begin
                    // Stray entries with nothing pending are dropped
                    if (left_reg != '0)
                    begin
                        if (cursor_reg < CNT_W'(raft_rx_pkg::LOG_DEPTH))
                        begin
                            wr_en          = 1'b1;
                            last_idx_next  = cursor_reg[IDX_W-1:0];
                            last_term_next = s1_item_reg.entry_term;
                        end
                        cursor_next = cursor_reg + 1'b1;
                        left_next   = left_reg - 1'b1;
                        if (left_reg == CNT_W'(1))
                        begin
                            res_valid = 1'b1;
                            res_acc   = 1'b1;
                        end
                    end
                end

                raft_rx_pkg::OP_TIMER:
                begin
                    res_valid = 1'b1;
                    unique case (role_reg)
                        raft_rx_pkg::ROLE_FOLLOWER,
                        raft_rx_pkg::ROLE_CANDIDATE:
                        begin
                            if (role_reg == raft_rx_pkg::ROLE_FOLLOWER && hb_reg)
                                hb_next = 1'b0;
                            else
                            begin
                                // Start an election; the term saturates at its maximum
                                if (term_reg != raft_rx_pkg::TERM_MAX)
                                    term_next = term_reg + 1'b1;
                                role_next        = raft_rx_pkg::ROLE_CANDIDATE;
                                vote_cast_next   = 1'b1;
                                vote_target_next = node_id_reg;
                            end
                        end
                        default:
                        begin
                            // Leader: hold everything
                        end
                    endcase
                end

                default:
                begin
                end
            endcase
        end
    end

    // Log store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            log_mem[wr_addr] <= s1_item_reg.entry_term;
        if (in_fire)
        begin
            mem_rd_reg   <= log_mem[in_item.ref_index];
            fwd_data_reg <= s1_item_reg.entry_term;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
            s1_op_reg   <= raft_rx_pkg::opcode_t'(s_tuser);
        end
        if (s1_fire && res_valid)
        begin
            out_data_reg.reply_term   <= term_next;
            out_data_reg.accepted     <= res_acc;
            out_data_reg.role         <= role_next;
            out_data_reg.commit_index <= commit_next;
            out_data_reg.last_index   <= last_idx_next;
            out_data_reg.log_full     <= res_full;
        end
    end

    // Control and node state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg     <= '0;
            term_reg        <= '0;
            vote_target_reg <= '0;
            vote_cast_reg   <= 1'b0;
            role_reg        <= raft_rx_pkg::ROLE_FOLLOWER;
            last_idx_reg    <= '0;
            last_term_reg   <= '0;
            commit_reg      <= '0;
            hb_reg          <= 1'b0;
            cursor_reg      <= '0;
            left_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                node_id_reg <= cfg_data;
            term_reg        <= term_next;
            vote_target_reg <= vote_target_next;
            vote_cast_reg   <= vote_cast_next;
            role_reg        <= role_next;
            last_idx_reg    <= last_idx_next;
            last_term_reg   <= last_term_next;
            commit_reg      <= commit_next;
            hb_reg          <= hb_next;
            cursor_reg      <= cursor_next;
            left_reg        <= left_next;

            // Advance the input stage
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            // Forward a write that hits the address read at the same edge
            if (in_fire)
                fwd_hit_reg <= wr_en && (wr_addr == in_item.ref_index);

            // Load or drain the result register
            if (s1_fire && res_valid)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/raft_rx_checker.sv =====
module raft_rx_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [raft_rx_pkg::M_DATA_W-1:0] m_tdata
);

    raft_rx_pkg::result_t          res;
    logic [raft_rx_pkg::TERM_W-1:0] prev_term_reg;

    assign res = raft_rx_pkg::result_t'(m_tdata[raft_rx_pkg::OUT_W-1:0]);

    // Track the term of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_term_reg <= '0;
        else if (m_tvalid && m_tready)
            prev_term_reg <= res.reply_term;
    end

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The term never goes backward between delivered words
    a_term_mono: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> res.reply_term >= prev_term_reg)
        else $error("reply term decreased");

    // An overrun reject is never an accept and leaves the node a follower
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.log_full |->
            !res.accepted && res.role == raft_rx_pkg::ROLE_FOLLOWER)
        else $error("log full with accept or non-follower role");

    // This unit never promotes itself to leader
    a_no_leader: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.role != raft_rx_pkg::ROLE_LEADER)
        else $error("leader role reported");

endmodule

bind raft_rpc_receiver_unit raft_rx_checker u_raft_rx_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int S_DATA_W  = raft_rx_pkg::S_DATA_W;
    localparam int M_DATA_W  = raft_rx_pkg::M_DATA_W;
    localparam int IN_W      = raft_rx_pkg::IN_W;
    localparam int OUT_W     = raft_rx_pkg::OUT_W;
    localparam int NODE_W    = raft_rx_pkg::NODE_W;
    localparam int TERM_W    = raft_rx_pkg::TERM_W;
    localparam int IDX_W     = raft_rx_pkg::IDX_W;
    localparam int CNT_W     = raft_rx_pkg::CNT_W;
    localparam int LOG_DEPTH = raft_rx_pkg::LOG_DEPTH;
    localparam logic [TERM_W-1:0] TERM_MAX = raft_rx_pkg::TERM_MAX;

    typedef raft_rx_pkg::item_t   item_t;
    typedef raft_rx_pkg::result_t result_t;
    typedef raft_rx_pkg::opcode_t opcode_t;
    typedef raft_rx_pkg::role_t   role_t;

    // Hard stop for a hung handshake.
    localparam int LIMIT_CYCLES = 400000;
    // Words per random phase; three phases, one node id each.
    localparam int PHASE_WORDS  = 200;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we;
    logic [NODE_W-1:0]   cfg_data;

    always #10 clk = ~clk;

    raft_rpc_receiver_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Follower state as the testbench sees it
    // ------------------------------------------------------------------
    logic [TERM_W-1:0] cur_term;
    logic [NODE_W-1:0] voted_for;
    bit                has_voted;
    role_t             cur_role;
    logic [TERM_W-1:0] term_log [0:LOG_DEPTH-1];
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  commit_idx;
    bit                hb_mark;
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  entries_due;
    logic [NODE_W-1:0] my_id;

    // Replies owed by the block, oldest first
    result_t replies_due [$];

    // One row of the directed script; typed rows carry a hand-written reply
    typedef struct {
        opcode_t op;
        item_t   msg;
        bit      typed;
        result_t want;
    } row_t;

    row_t script [$];
    int   tail_at;

    int errors        = 0;
    int words_sent    = 0;
    int replies_seen  = 0;
    int grants_seen   = 0;
    int full_seen     = 0;
    int burst_left    = 0;
    int stall_left    = 0;
    int cycles        = 0;
    bit steady        = 1'b0;

    function automatic void make_reply(output result_t r, input bit acc, input bit full);
        r.reply_term   = cur_term;
        r.accepted     = acc;
        r.role         = cur_role;
        r.commit_index = commit_idx;
        r.last_index   = last_idx;
        r.log_full     = full;
    endfunction

    // A newer term demotes the node and forgets its vote.
    function automatic void take_term(input logic [TERM_W-1:0] t);
        cur_term  = t;
        cur_role  = raft_rx_pkg::ROLE_FOLLOWER;
        has_voted = 1'b0;
    endfunction

    // Stand for election: bump the term (saturating) and vote for ourselves.
    function automatic void run_election();
        if (cur_term != TERM_MAX)
            cur_term = cur_term + 1'b1;
        cur_role  = raft_rx_pkg::ROLE_CANDIDATE;
        has_voted = 1'b1;
        voted_for = my_id;
    endfunction

    // Apply one accepted word to the follower state; return 1 when it owes a reply.
    function automatic bit node_reply(input opcode_t op, input item_t msg, output result_t r);
        logic [TERM_W-1:0] mine;
        bit                grant;
        int                stop;
        r = '0;
        case (op)
            raft_rx_pkg::OP_VOTE:
            begin
                grant = 1'b0;
                if (msg.msg_term >= cur_term)
                begin
                    if (msg.msg_term > cur_term)
                        take_term(msg.msg_term);
                    if (!has_voted || voted_for == msg.peer_id)
                    begin
                        // Candidate log must be at least as fresh: last term, then length
                        mine = term_log[last_idx];
                        if (mine != msg.ref_term)
                            grant = mine < msg.ref_term;
                        else
                            grant = last_idx <= msg.ref_index;
                        if (grant)
                        begin
                            has_voted = 1'b1;
                            voted_for = msg.peer_id;
                            hb_mark   = 1'b1;
                        end
                    end
                end
                make_reply(r, grant, 1'b0);
                return 1'b1;
            end
            raft_rx_pkg::OP_APPEND:
            begin
                entries_due = '0;
                if (msg.msg_term < cur_term)
                begin
                    make_reply(r, 1'b0, 1'b0);
                    return 1'b1;
                end
                hb_mark = 1'b1;
                if (msg.msg_term > cur_term)
                    take_term(msg.msg_term);
                else if (cur_role == raft_rx_pkg::ROLE_CANDIDATE)
                    cur_role = raft_rx_pkg::ROLE_FOLLOWER;
                if (msg.ref_index > last_idx || term_log[msg.ref_index] != msg.ref_term)
                begin
                    make_reply(r, 1'b0, 1'b0);
                    return 1'b1;
                end
                stop = int'(msg.ref_index) + int'(msg.entry_count);
                if (stop > LOG_DEPTH - 1)
                begin
                    make_reply(r, 1'b0, 1'b1);
                    return 1'b1;
                end
                // Truncate to the match point and arm the entry writer
                last_idx    = msg.ref_index;
                wr_ptr      = CNT_W'(msg.ref_index) + 1'b1;
                entries_due = msg.entry_count;
                if (msg.leader_commit > commit_idx)
                    commit_idx = (int'(msg.leader_commit) < stop) ?
                                 msg.leader_commit : IDX_W'(stop);
                if (msg.entry_count == 0)
                begin
                    make_reply(r, 1'b1, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
            raft_rx_pkg::OP_ENTRY:
            begin
                if (entries_due == 0)
                    return 1'b0;
                term_log[wr_ptr[IDX_W-1:0]] = msg.entry_term;
                last_idx    = wr_ptr[IDX_W-1:0];
                wr_ptr      = wr_ptr + 1'b1;
                entries_due = entries_due - 1'b1;
                if (entries_due == 0)
                begin
                    make_reply(r, 1'b1, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                // Election timer: a heartbeat mark buys one more period
                case (cur_role)
                    raft_rx_pkg::ROLE_FOLLOWER:
                    begin
                        if (hb_mark)
                            hb_mark = 1'b0;
                        else
                            run_election();
                    end
                    raft_rx_pkg::ROLE_CANDIDATE:
                        run_election();
                    default:
                        ;
                endcase
                make_reply(r, 1'b0, 1'b0);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic item_t mk_item(input logic [TERM_W-1:0] term, input int peer,
                                      input int rindex, input logic [TERM_W-1:0] rterm,
                                      input int count, input int lcommit,
                                      input logic [TERM_W-1:0] eterm);
        item_t m;
        m.msg_term      = term;
        m.peer_id       = NODE_W'(peer);
        m.ref_index     = IDX_W'(rindex);
        m.ref_term      = rterm;
        m.entry_count   = CNT_W'(count);
        m.leader_commit = IDX_W'(lcommit);
        m.entry_term    = eterm;
        return m;
    endfunction

    function automatic result_t mk_reply(input logic [TERM_W-1:0] term, input bit acc,
                                         input role_t rl, input int commit, input int last,
                                         input bit full);
        result_t r;
        r.reply_term   = term;
        r.accepted     = acc;
        r.role         = rl;
        r.commit_index = IDX_W'(commit);
        r.last_index   = IDX_W'(last);
        r.log_full     = full;
        return r;
    endfunction

    // Random filler for every field; callers overwrite what the opcode uses.
    function automatic item_t noise_item();
        return mk_item($urandom, $urandom_range(0, 15), $urandom_range(0, 1023), $urandom,
                       $urandom_range(0, 1024), $urandom_range(0, 1023), $urandom);
    endfunction

    task automatic add_row(input opcode_t op, input item_t msg, input bit typed,
                           input result_t want);
        row_t row;
        row.op    = op;
        row.msg   = msg;
        row.typed = typed;
        row.want  = want;
        script    = {script, row};
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: enter and leave at a falling edge. Gaps fall between bursts.
    // ------------------------------------------------------------------
    task automatic send_word(input opcode_t op, input item_t msg, input bit typed,
                             input result_t want);
        int      gap;
        bit      owed;
        result_t r;
        if (burst_left == 0)
        begin
            if (steady)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(4, 20);
            else
                gap = $urandom_range(0, 2);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {{(S_DATA_W - IN_W){1'b0}}, msg};
        // Hold the word until the block takes it
        do
            @(posedge clk);
        while (!s_tready);
        owed = node_reply(op, msg, r);
        if (typed)
            r = want;
        if (owed)
            replies_due = {replies_due, r};
        words_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // Drain all owed replies, let the pipe empty, then load a new node id.
    task automatic set_node_id(input logic [NODE_W-1:0] id);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (replies_due.size() != 0)
            @(negedge clk);
        // A trailing entry word owes nothing; give it time to retire
        repeat (4) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = id;
        @(negedge clk);
        cfg_we   = 1'b0;
        my_id    = id;
    endtask

    task automatic walk_script(input int first, input int last);
        for (int i = first; i < last; i++)
            send_word(script[i].op, script[i].msg, script[i].typed, script[i].want);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed appends and votes built on the
    // current state, with timers, stale or broken headers and stray entries.
    // ------------------------------------------------------------------
    task automatic random_traffic(input int n_words);
        int    sent;
        int    kind;
        int    pick;
        int    n_ent;
        int    lim;
        int    idx;
        bit    live;
        item_t msg;
        sent = 0;
        while (sent < n_words)
        begin
            // Every fourth stretch runs with no idling on either side
            steady = ((sent / 60) % 4) == 3;
            msg    = noise_item();
            kind   = $urandom_range(0, 99);
            if (kind < 40)
            begin
                msg.ref_index = IDX_W'($urandom_range(0, last_idx));
                msg.ref_term  = term_log[msg.ref_index];
                msg.msg_term  = cur_term + (($urandom_range(0, 3) == 0) ? 1 : 0);
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    msg.entry_count = '0;
                else if (pick < 17)
                    msg.entry_count = CNT_W'($urandom_range(1, 6));
                else if (pick < 19)
                    msg.entry_count = CNT_W'($urandom_range(7, 40));
                else
                    // Push the end past the store
                    msg.entry_count = CNT_W'(1024 - int'(msg.ref_index) +
                                             int'($urandom_range(0, msg.ref_index)));
                if ($urandom_range(0, 1) == 1)
                begin
                    lim = int'(last_idx) + int'(msg.entry_count);
                    if (lim > LOG_DEPTH - 1)
                        lim = LOG_DEPTH - 1;
                    msg.leader_commit = IDX_W'($urandom_range(0, lim));
                end
                send_word(raft_rx_pkg::OP_APPEND, msg, 1'b0, '0);
                sent++;
                n_ent = int'(entries_due);
                // Cut some runs short; the next header drops what is left
                if (n_ent > 0 && $urandom_range(0, 7) == 0)
                    n_ent = $urandom_range(0, n_ent - 1);
                repeat (n_ent)
                begin
                    msg = noise_item();
                    if ($urandom_range(0, 3) != 0)
                        msg.entry_term = cur_term;
                    send_word(raft_rx_pkg::OP_ENTRY, msg, 1'b0, '0);
                    sent++;
                end
            end
            else if (kind < 65)
            begin
                if (cur_term > 2 && $urandom_range(0, 5) == 0)
                    msg.msg_term = cur_term - 1'b1;
                else
                    msg.msg_term = cur_term + $urandom_range(0, 2);
                if ($urandom_range(0, 3) != 0)
                begin
                    // Near our own log so that both freshness tests flip
                    idx = int'(last_idx) + int'($urandom_range(0, 4)) - 2;
                    if (idx < 0)
                        idx = 0;
                    if (idx > LOG_DEPTH - 1)
                        idx = LOG_DEPTH - 1;
                    msg.ref_index = IDX_W'(idx);
                    msg.ref_term  = term_log[last_idx] + $urandom_range(0, 2) - 1;
                end
                send_word(raft_rx_pkg::OP_VOTE, msg, 1'b0, '0);
                sent++;
            end
            else if (kind < 80)
            begin
                send_word(raft_rx_pkg::OP_TIMER, msg, 1'b0, '0);
                sent++;
            end
            else if (kind < 90)
            begin
                // Stale or unmatched header with random content
                if (cur_term > 2 && $urandom_range(0, 1) == 1)
                    msg.msg_term = cur_term - $urandom_range(1, 2);
                else
                    msg.msg_term = cur_term;
                send_word(raft_rx_pkg::OP_APPEND, msg, 1'b0, '0);
                sent++;
            end
            else
            begin
                // Entry word; only counts when a run is still open
                live = entries_due != 0;
                send_word(raft_rx_pkg::OP_ENTRY, msg, 1'b0, '0);
                if (live)
                    sent++;
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: toggle ready with random hold times, except in steady stretches.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            m_tready   <= ~m_tready;
            stall_left <= m_tready ? $urandom_range(0, 6) : $urandom_range(0, 10);
        end
    end

    // ------------------------------------------------------------------
    // Reply checker: compare each taken word with the oldest owed reply.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_replies
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[OUT_W-1:0];
            if (replies_due.size() == 0)
            begin
                $display("%0t ns: unexpected reply, expected none, got term %0d accepted %0d",
                         $time, got.reply_term, got.accepted);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("reply_term", want.reply_term, got.reply_term);
                check_field("accepted", want.accepted, got.accepted);
                check_field("role", want.role, got.role);
                check_field("commit_index", want.commit_index, got.commit_index);
                check_field("last_index", want.last_index, got.last_index);
                check_field("log_full", want.log_full, got.log_full);
                replies_seen++;
                if (got.accepted)
                    grants_seen++;
                if (got.log_full)
                    full_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t ns: timeout with %0d replies outstanding", $time, replies_due.size());
            $display("[raft_rpc_receiver_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = raft_rx_pkg::OP_VOTE;
        cfg_we   = 1'b0;
        cfg_data = '0;

        cur_term    = '0;
        voted_for   = '0;
        has_voted   = 1'b0;
        cur_role    = raft_rx_pkg::ROLE_FOLLOWER;
        last_idx    = '0;
        commit_idx  = '0;
        hb_mark     = 1'b0;
        wr_ptr      = '0;
        entries_due = '0;
        my_id       = '0;
        for (int i = 0; i < LOG_DEPTH; i++)
            term_log[i] = '0;

        // Opening script, run with node id 0 straight after reset.
        // Election from cold: no heartbeat yet
        add_row(raft_rx_pkg::OP_TIMER,  mk_item(0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_reply(1, 1'b0, raft_rx_pkg::ROLE_CANDIDATE, 0, 0, 1'b0));
        // Same term, vote already cast for ourselves
        add_row(raft_rx_pkg::OP_VOTE,   mk_item(1, 5, 0, 0, 0, 0, 0), 1'b1,
                mk_reply(1, 1'b0, raft_rx_pkg::ROLE_CANDIDATE, 0, 0, 1'b0));
        // Candidate times out again
        add_row(raft_rx_pkg::OP_TIMER,  mk_item(0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_reply(2, 1'b0, raft_rx_pkg::ROLE_CANDIDATE, 0, 0, 1'b0));
        // Heartbeat at equal term steps the candidate down
        add_row(raft_rx_pkg::OP_APPEND, mk_item(2, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_reply(2, 1'b1, raft_rx_pkg::ROLE_FOLLOWER, 0, 0, 1'b0));
        // Heartbeat mark absorbs one timer
        add_row(raft_rx_pkg::OP_TIMER,  mk_item(0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_reply(2, 1'b0, raft_rx_pkg::ROLE_FOLLOWER, 0, 0, 1'b0));
        // Three entries, commit clamped to the new end; reply on the last one
        add_row(raft_rx_pkg::OP_APPEND, mk_item(2, 0, 0, 0, 3, 1023, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 2), 1'b0, '0);
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b1,
                mk_reply(2, 1'b1, raft_rx_pkg::ROLE_FOLLOWER, 3, 3, 1'b0));
        // Stray entry: nothing owed
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 5), 1'b0, '0);
        // Previous index beyond the log
        add_row(raft_rx_pkg::OP_APPEND, mk_item(2, 0, 100, 0, 0, 0, 0), 1'b1,
                mk_reply(2, 1'b0, raft_rx_pkg::ROLE_FOLLOWER, 3, 3, 1'b0));
        // Previous term mismatch
        add_row(raft_rx_pkg::OP_APPEND, mk_item(2, 0, 2, 5, 0, 0, 0), 1'b1,
                mk_reply(2, 1'b0, raft_rx_pkg::ROLE_FOLLOWER, 3, 3, 1'b0));
        // Overrun with a count equal to the store depth
        add_row(raft_rx_pkg::OP_APPEND, mk_item(2, 0, 0, 0, 1024, 0, 0), 1'b1,
                mk_reply(2, 1'b0, raft_rx_pkg::ROLE_FOLLOWER, 3, 3, 1'b1));
        // Higher term on append
        add_row(raft_rx_pkg::OP_APPEND, mk_item(7, 0, 3, 32'hFFFF_FFFF, 0, 0, 0), 1'b1,
                mk_reply(7, 1'b1, raft_rx_pkg::ROLE_FOLLOWER, 3, 3, 1'b0));
        // Stale leader
        add_row(raft_rx_pkg::OP_APPEND, mk_item(6, 0, 3, 32'hFFFF_FFFF, 0, 0, 0), 1'b1,
                mk_reply(7, 1'b0, raft_rx_pkg::ROLE_FOLLOWER, 3, 3, 1'b0));
        // New header while entries are still pending
        add_row(raft_rx_pkg::OP_APPEND, mk_item(7, 0, 1, 1, 5, 2, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 7), 1'b0, '0);
        add_row(raft_rx_pkg::OP_APPEND, mk_item(7, 0, 2, 7, 1, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 8), 1'b0, '0);
        // Votes: grant, refuse a second candidate, re-grant, stale log, short log
        add_row(raft_rx_pkg::OP_VOTE,   mk_item(9, 9, 3, 8, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_VOTE,   mk_item(9, 10, 1023, 9, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_VOTE,   mk_item(9, 9, 3, 8, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_VOTE,   mk_item(10, 3, 1023, 7, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_VOTE,   mk_item(11, 4, 2, 8, 0, 0, 0), 1'b0, '0);
        tail_at = script.size();
        // Closing script: the term only grows, so saturation comes last
        add_row(raft_rx_pkg::OP_APPEND, mk_item(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_TIMER,  mk_item(0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_TIMER,  mk_item(0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_TIMER,  mk_item(0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_VOTE,
                mk_item(32'hFFFF_FFFF, 15, 1023, 32'hFFFF_FFFF, 0, 0, 0), 1'b0, '0);
        add_row(raft_rx_pkg::OP_APPEND, mk_item(32'hFFFF_FFFF, 0, 0, 0, 2, 1023, 0),
                1'b0, '0);
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(raft_rx_pkg::OP_ENTRY,  mk_item(0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_node_id(4'd0);
        walk_script(0, tail_at);

        set_node_id(4'd15);
        random_traffic(PHASE_WORDS);
        set_node_id(NODE_W'($urandom_range(1, 14)));
        random_traffic(PHASE_WORDS);
        set_node_id(4'd0);
        random_traffic(PHASE_WORDS);

        walk_script(tail_at, script.size());
        s_tvalid = 1'b0;

        // Drain, then let the pipe run on to show any extra reply
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d words through votes, appends, entries and timers under 3 node ids;",
                 words_sent);
        $display("checked %0d replies (%0d accepted, %0d log-full), final term %0d.",
                 replies_seen, grants_seen, full_seen, cur_term);
        if (errors == 0)
            $display("[raft_rpc_receiver_unit] OK");
        else
            $display("[raft_rpc_receiver_unit] ERROR");
        $finish;
    end

endmodule
